@@ src/comment_aware_brace_matcher_macros.svh @@
`ifndef COMMENT_AWARE_BRACE_MATCHER_MACROS_SVH
`define COMMENT_AWARE_BRACE_MATCHER_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define CABM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brace matcher check failed");

// next-cycle implication, checked on every clock outside reset
`define CABM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brace matcher check failed");

`endif

@@ src/cabm_pkg.sv @@
package cabm_pkg;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int OFFSET_W = 16;
  localparam int DEPTH_W  = 8;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BTICK  = 8'h60;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;

  typedef enum logic [STATUS_W-1:0] {
    ST_SCAN   = 3'd0,
    ST_MATCH  = 3'd1,
    ST_UNDER  = 3'd2,
    ST_UNTERM = 3'd3,
    ST_OVER   = 3'd4,
    ST_IDLE   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    QK_NONE     = 2'd0,
    QK_SINGLE   = 2'd1,
    QK_DOUBLE   = 2'd2,
    QK_BACKTICK = 2'd3
  } quote_t;

  function automatic quote_t quote_code(input logic [BYTE_W-1:0] c);
    quote_t q;
    unique case (c)
      CH_SQUOTE: q = QK_SINGLE;
      CH_DQUOTE: q = QK_DOUBLE;
      CH_BTICK:  q = QK_BACKTICK;
      default:   q = QK_NONE;
    endcase
    return q;
  endfunction

endpackage

@@ src/cabm_in_if.sv @@
interface cabm_in_if;
  logic                         valid;
  logic                         ready;
  logic [cabm_pkg::BYTE_W-1:0]  text_byte;
  logic                         start_req;
  logic                         last_byte;

  modport source (output valid, text_byte, start_req, last_byte, input ready);
  modport sink (input valid, text_byte, start_req, last_byte, output ready);
endinterface

@@ src/cabm_out_if.sv @@
interface cabm_out_if;
  logic                           valid;
  logic                           ready;
  logic [cabm_pkg::STATUS_W-1:0]  status;
  logic [cabm_pkg::OFFSET_W-1:0]  offset;
  logic [cabm_pkg::DEPTH_W-1:0]   depth;

  modport source (output valid, status, offset, depth, input ready);
  modport sink (input valid, status, offset, depth, output ready);
endinterface

@@ src/comment_aware_brace_matcher.sv @@
// A word waits in the input register until the result side takes it. Throughput:
// one word per cycle while out_ch.ready is high; an input register and a result
// register part the two sides, and the scan state updates as a word moves between
// them. Reset: synchronous rst empties both registers and clears all scan state;
// the block then reports idle for every word until one carries start_req.
`include "comment_aware_brace_matcher_macros.svh"

module comment_aware_brace_matcher #(
  parameter int MAX_DEPTH  = 255,
  parameter int MAX_LENGTH = 65536
) (
  input logic        clk,
  input logic        rst,
  cabm_in_if.sink    in_ch,
  cabm_out_if.source out_ch
);
  import cabm_pkg::*;

  localparam int POS_W = $clog2(MAX_LENGTH + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'((MAX_DEPTH > 255) ? 255 : MAX_DEPTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_LENGTH - 1);

  logic                hold_valid;
  logic [BYTE_W-1:0]   hold_byte;
  logic                hold_start;
  logic                hold_last;

  logic                res_valid;
  status_t             res_status;
  logic [OFFSET_W-1:0] res_offset;
  logic [DEPTH_W-1:0]  res_depth;

  logic [DEPTH_W-1:0]  brace_depth;
  quote_t              quote_kind;
  logic                escape_pending;
  logic                in_line_comment;
  logic                in_block_comment;
  logic                slash_pending;
  logic                star_pending;
  logic [POS_W-1:0]    position;
  logic                scan_active;

  logic [DEPTH_W-1:0]  brace_depth_next;
  quote_t              quote_kind_next;
  logic                escape_pending_next;
  logic                in_line_comment_next;
  logic                in_block_comment_next;
  logic                slash_pending_next;
  logic                star_pending_next;
  logic [POS_W-1:0]    position_next;
  logic                scan_active_next;

  status_t             status_next;
  logic [OFFSET_W-1:0] offset_next;
  logic [DEPTH_W-1:0]  depth_next;

  logic                advance;

  assign advance      = hold_valid && (!res_valid || out_ch.ready);
  assign in_ch.ready  = !hold_valid || advance;
  assign out_ch.valid = res_valid;
  assign out_ch.status = res_status;
  assign out_ch.offset = res_offset;
  assign out_ch.depth  = res_depth;

  always_comb begin
    logic code;
    code = 1'b0;
    brace_depth_next      = brace_depth;
    quote_kind_next       = quote_kind;
    escape_pending_next   = escape_pending;
    in_line_comment_next  = in_line_comment;
    in_block_comment_next = in_block_comment;
    slash_pending_next    = slash_pending;
    star_pending_next     = star_pending;
    position_next         = position;
    scan_active_next      = scan_active;
    status_next           = ST_SCAN;
    offset_next           = '0;
    depth_next            = '0;

    if (hold_start) begin
      brace_depth_next      = '0;
      quote_kind_next       = QK_NONE;
      escape_pending_next   = 1'b0;
      in_line_comment_next  = 1'b0;
      in_block_comment_next = 1'b0;
      slash_pending_next    = 1'b0;
      star_pending_next     = 1'b0;
      position_next         = '0;
      scan_active_next      = 1'b1;
    end

    if (!scan_active_next) begin
      status_next = ST_IDLE;
    end else begin
      offset_next = (32'(position_next) > 32'(OFFSET_MAX)) ? OFFSET_MAX
                                                           : OFFSET_W'(position_next);
      if (in_line_comment_next) begin
        if (hold_byte == CH_NL) in_line_comment_next = 1'b0;
      end else if (in_block_comment_next) begin
        if (star_pending_next && hold_byte == CH_SLASH) begin
          in_block_comment_next = 1'b0;
          star_pending_next     = 1'b0;
        end else begin
          star_pending_next = (hold_byte == CH_STAR);
        end
      end else if (quote_kind_next != QK_NONE) begin
        if (escape_pending_next) escape_pending_next = 1'b0;
        else if (hold_byte == CH_BSLASH) escape_pending_next = 1'b1;
        else if (quote_code(hold_byte) == quote_kind_next) quote_kind_next = QK_NONE;
      end else if (slash_pending_next) begin
        slash_pending_next = 1'b0;
        if (hold_byte == CH_SLASH) begin
          in_line_comment_next = 1'b1;
        end else if (hold_byte == CH_STAR) begin
          in_block_comment_next = 1'b1;
          star_pending_next     = 1'b0;
        end else begin
          code = 1'b1;
        end
      end else begin
        code = 1'b1;
      end

      if (code) begin
        if (hold_byte == CH_SLASH) begin
          slash_pending_next = 1'b1;
        end else if (quote_code(hold_byte) != QK_NONE) begin
          quote_kind_next = quote_code(hold_byte);
        end else if (hold_byte == CH_LBRACE) begin
          if (brace_depth_next >= DEPTH_LIMIT) status_next = ST_OVER;
          else brace_depth_next = brace_depth_next + 1'b1;
        end else if (hold_byte == CH_RBRACE) begin
          if (brace_depth_next == '0) begin
            status_next = ST_UNDER;
          end else begin
            if (brace_depth_next == DEPTH_W'(1)) status_next = ST_MATCH;
            brace_depth_next = brace_depth_next - 1'b1;
          end
        end
      end

      if (status_next == ST_SCAN && (hold_last || position_next >= LAST_POS))
        status_next = ST_UNTERM;

      depth_next = brace_depth_next;

      if (status_next == ST_SCAN) begin
        if (32'(position_next) < 32'(MAX_LENGTH)) position_next = position_next + 1'b1;
      end else begin
        brace_depth_next      = '0;
        quote_kind_next       = QK_NONE;
        escape_pending_next   = 1'b0;
        in_line_comment_next  = 1'b0;
        in_block_comment_next = 1'b0;
        slash_pending_next    = 1'b0;
        star_pending_next     = 1'b0;
        position_next         = '0;
        scan_active_next      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid       <= 1'b0;
      res_valid        <= 1'b0;
      brace_depth      <= '0;
      quote_kind       <= QK_NONE;
      escape_pending   <= 1'b0;
      in_line_comment  <= 1'b0;
      in_block_comment <= 1'b0;
      slash_pending    <= 1'b0;
      star_pending     <= 1'b0;
      position         <= '0;
      scan_active      <= 1'b0;
    end else begin
      if (in_ch.ready) hold_valid <= in_ch.valid;
      if (advance) begin
        res_valid        <= 1'b1;
        brace_depth      <= brace_depth_next;
        quote_kind       <= quote_kind_next;
        escape_pending   <= escape_pending_next;
        in_line_comment  <= in_line_comment_next;
        in_block_comment <= in_block_comment_next;
        slash_pending    <= slash_pending_next;
        star_pending     <= star_pending_next;
        position         <= position_next;
        scan_active      <= scan_active_next;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // hold payload until the stage advances
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hold_byte  <= in_ch.text_byte;
      hold_start <= in_ch.start_req;
      hold_last  <= in_ch.last_byte;
    end
    if (advance) begin
      res_status <= status_next;
      res_offset <= offset_next;
      res_depth  <= depth_next;
    end
  end

  `CABM_ASSERT_NOW(a_depth_limit, 1'b1, brace_depth <= DEPTH_LIMIT)
  `CABM_ASSERT_NOW(a_idle_clear, !scan_active,
                   brace_depth == '0 && position == '0 && quote_kind == QK_NONE)
  `CABM_ASSERT_NOW(a_one_comment, 1'b1, !(in_line_comment && in_block_comment))
  `CABM_ASSERT_NOW(a_idle_word, res_valid && res_status == ST_IDLE,
                   res_offset == '0 && res_depth == '0)
  `CABM_ASSERT_NEXT(a_end_clears, advance && status_next != ST_SCAN, !scan_active)

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import cabm_pkg::*;

  localparam int DEPTH_LIMIT  = 255;
  localparam int LENGTH_LIMIT = 65536;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int WORDS_PER_PHASE = 32;

  typedef struct packed {
    status_t               status;
    logic [OFFSET_W-1:0]   offset;
    logic [DEPTH_W-1:0]    depth;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text;
    logic              start;
    logic              is_last;
    logic              typed;
    result_t           want;
  } row_t;

  localparam result_t NO_RESULT = '{ST_SCAN, '0, '0};

  logic clk = 1'b0;
  logic rst;

  cabm_in_if  in_ch ();
  cabm_out_if out_ch ();

  comment_aware_brace_matcher #(
    .MAX_DEPTH  (DEPTH_LIMIT),
    .MAX_LENGTH (LENGTH_LIMIT)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  result_t pending_results[$];
  int      mismatches  = 0;
  int      cycle_count = 0;
  int      active_words = 0;
  int      send_idle = 0;
  int      stall_pct = 0;
  int      hold_left = 0;

  // scan state tracked alongside the block
  int unsigned open_depth;
  quote_t      quote_open;
  bit          escape_next;
  bit          line_cmt;
  bit          block_cmt;
  bit          slash_seen;
  bit          star_seen;
  int unsigned scan_pos;
  bit          scanning;

  row_t script [30] = '{
    '{8'h61,     1'b0, 1'b0, 1'b1, '{ST_IDLE,   16'd0, 8'd0}},
    '{8'hFF,     1'b0, 1'b1, 1'b1, '{ST_IDLE,   16'd0, 8'd0}},
    '{CH_RBRACE, 1'b1, 1'b0, 1'b1, '{ST_UNDER,  16'd0, 8'd0}},
    '{8'h00,     1'b1, 1'b1, 1'b1, '{ST_UNTERM, 16'd0, 8'd0}},
    '{CH_LBRACE, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{CH_DQUOTE, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_DQUOTE, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_RBRACE, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_DQUOTE, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_BTICK,  1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_RBRACE, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_BTICK,  1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_SQUOTE, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_SQUOTE, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_RBRACE, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_NL,     1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_STAR,   1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_STAR,   1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h61,     1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_RBRACE, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_LBRACE, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{CH_LBRACE, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{CH_SLASH,  1'b0, 1'b1, 1'b1, '{ST_UNTERM, 16'd1, 8'd1}}
  };

  function automatic void clear_scan_state();
    open_depth  = 0;
    quote_open  = QK_NONE;
    escape_next = 1'b0;
    line_cmt    = 1'b0;
    block_cmt   = 1'b0;
    slash_seen  = 1'b0;
    star_seen   = 1'b0;
    scan_pos    = 0;
    scanning    = 1'b0;
  endfunction

  function automatic logic [BYTE_W-1:0] closing_quote(quote_t q);
    case (q)
      QK_SINGLE: return CH_SQUOTE;
      QK_DOUBLE: return CH_DQUOTE;
      default:   return CH_BTICK;
    endcase
  endfunction

  function automatic status_t code_byte_status(logic [BYTE_W-1:0] c);
    if (c == CH_SLASH) begin
      slash_seen = 1'b1;
    end else if (c == CH_SQUOTE) begin
      quote_open = QK_SINGLE;
    end else if (c == CH_DQUOTE) begin
      quote_open = QK_DOUBLE;
    end else if (c == CH_BTICK) begin
      quote_open = QK_BACKTICK;
    end else if (c == CH_LBRACE) begin
      if (open_depth >= DEPTH_LIMIT) return ST_OVER;
      open_depth++;
    end else if (c == CH_RBRACE) begin
      if (open_depth == 0) return ST_UNDER;
      open_depth--;
      if (open_depth == 0) return ST_MATCH;
    end
    return ST_SCAN;
  endfunction

  function automatic result_t predict_result(logic [BYTE_W-1:0] c, logic start,
                                             logic is_last);
    result_t r;
    status_t st;
    st = ST_SCAN;
    if (start) begin
      clear_scan_state();
      scanning = 1'b1;
    end
    if (!scanning) return '{ST_IDLE, '0, '0};
    r.offset = (scan_pos > 65535) ? OFFSET_MAX : scan_pos[OFFSET_W-1:0];
    if (line_cmt) begin
      if (c == CH_NL) line_cmt = 1'b0;
    end else if (block_cmt) begin
      if (star_seen && c == CH_SLASH) begin
        block_cmt = 1'b0;
        star_seen = 1'b0;
      end else begin
        star_seen = (c == CH_STAR);
      end
    end else if (quote_open != QK_NONE) begin
      if (escape_next) escape_next = 1'b0;
      else if (c == CH_BSLASH) escape_next = 1'b1;
      else if (c == closing_quote(quote_open)) quote_open = QK_NONE;
    end else if (slash_seen) begin
      slash_seen = 1'b0;
      if (c == CH_SLASH) begin
        line_cmt = 1'b1;
      end else if (c == CH_STAR) begin
        block_cmt = 1'b1;
        star_seen = 1'b0;
      end else begin
        st = code_byte_status(c);
      end
    end else begin
      st = code_byte_status(c);
    end
    if (st == ST_SCAN && (is_last || scan_pos + 1 >= LENGTH_LIMIT)) st = ST_UNTERM;
    r.status = st;
    r.depth  = open_depth[DEPTH_W-1:0];
    if (st == ST_SCAN) begin
      if (scan_pos < LENGTH_LIMIT) scan_pos++;
    end else begin
      clear_scan_state();
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_text();
    int r;
    r = $urandom_range(99);
    if (r < 14) return CH_LBRACE;
    if (r < 26) return CH_RBRACE;
    if (r < 32) return CH_DQUOTE;
    if (r < 37) return CH_SQUOTE;
    if (r < 42) return CH_BTICK;
    if (r < 48) return CH_BSLASH;
    if (r < 58) return CH_SLASH;
    if (r < 66) return CH_STAR;
    if (r < 72) return CH_NL;
    if (r < 85) return BYTE_W'(8'h61 + $urandom_range(25));
    return BYTE_W'($urandom_range(255));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic send_word(input logic [BYTE_W-1:0] text, input logic start,
                           input logic is_last, input logic typed = 1'b0,
                           input result_t want = NO_RESULT);
    result_t predicted;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= text;
    in_ch.start_req <= start;
    in_ch.last_byte <= is_last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = predict_result(text, start, is_last);
    if (predicted.status != ST_IDLE) active_words++;
    pending_results.insert(pending_results.size(), typed ? want : predicted);
  endtask

  task automatic send_random_scan();
    int len;
    int k;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
    for (k = 0; k < len; k++) begin
      send_word(pick_text(),
                (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0),
                (k == len - 1) && ($urandom_range(3) != 0));
    end
    // stray words between scans
    repeat ($urandom_range(2)) send_word(pick_text(), 1'b0, 1'($urandom_range(1)));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none pending, status", out_ch.status, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.offset !== want.offset)
          report_mismatch("offset", out_ch.offset, want.offset);
        if (out_ch.depth !== want.depth)
          report_mismatch("depth", out_ch.depth, want.depth);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[comment_aware_brace_matcher] ERROR");
      $finish;
    end
  end

  int send_idle_tbl [4] = '{0, 85, 0, 9};
  int stall_tbl     [4] = '{0, 0, 85, 9};

  initial begin
    int p;
    int goal;
    clear_scan_state();
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.text_byte <= '0;
    in_ch.start_req <= 1'b0;
    in_ch.last_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i])
      send_word(script[i].text, script[i].start, script[i].is_last, script[i].typed,
                script[i].want);

    // run into the depth limit
    send_word(CH_LBRACE, 1'b1, 1'b0);
    repeat (DEPTH_LIMIT) send_word(CH_LBRACE, 1'b0, 1'b0);

    for (p = 0; p < 4; p++) begin
      send_idle = send_idle_tbl[p];
      stall_pct = stall_tbl[p];
      // hold off the result side so the block fills and stalls its input
      if (p == 0) hold_left = 250;
      goal = active_words + WORDS_PER_PHASE;
      while (active_words < goal) send_random_scan();
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[comment_aware_brace_matcher] OK");
    end else begin
      $display("[comment_aware_brace_matcher] ERROR");
    end
    $finish;
  end

endmodule
